/* rtl/core/lfap_pkg.sv */
// lfap_pkg: shared types and constants of the led frame animation player
// no dependencies; imported by led_frame_animation_player and lfap_draw
package lfap_pkg;

  localparam int LED_LIMIT   = 12;
  localparam int LED_BYTES   = 3;
  localparam int LED_W       = 4;
  localparam int BYTE_W      = 8;
  localparam int ADDR_IN_W   = 12;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int INTERVAL_W  = 16;
  localparam int TOTAL_W     = 7;
  localparam int REPEAT_W    = 8;

  // request modes
  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_LOAD  = 2'd1;
  localparam logic [1:0] MODE_START = 2'd2;
  localparam logic [1:0] MODE_STOP  = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_INTERVAL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_FRAMES   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_COUNT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_LED      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LED_END        = 3'd4;

  typedef struct packed {
    logic [1:0]           mode;
    logic [ADDR_IN_W-1:0] load_addr;
    logic [BYTE_W-1:0]    load_data;
  } in_item_t;

  typedef struct packed {
    logic [LED_W-1:0]  led_index;
    logic [BYTE_W-1:0] red;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] blue;
    logic              last_of_frame;
    logic              finished;
  } out_item_t;

  // launch of one frame walk, from control to the draw engine
  typedef struct packed {
    logic go;
    logic blank;
    logic fin;
  } draw_req_t;

endpackage

/* rtl/core/led_frame_animation_player.sv */
// led_frame_animation_player: a tick, load or idle request is taken while busy stays low;
// a drawing request (start, expiring tick, stop while running) over n leds keeps busy high until
// its walk is done; results come one per led once its red, green and blue bytes pass the
// single read port of the frame store (one byte per cycle); results cannot be stalled
// synchronous active-low reset clears control state and loads register defaults; the frame store
// is not cleared and needs no clearing pass. depends on lfap_pkg, lfap_ram, lfap_draw
module led_frame_animation_player
  import lfap_pkg::*;
#(
  parameter int FRAME_BYTES = 36,
  parameter int MAX_FRAMES  = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  in_item_t              in_data,
  output logic                  out_strobe,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int DEPTH  = MAX_FRAMES * FRAME_BYTES;
  localparam int RAW    = $clog2(DEPTH);
  localparam int FIDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int FC_W   = ($clog2(MAX_FRAMES + 1) > TOTAL_W) ? $clog2(MAX_FRAMES + 1) : TOTAL_W;

  // configuration registers
  logic [INTERVAL_W-1:0] frame_interval_r;
  logic [TOTAL_W-1:0]    total_frames_r;
  logic [REPEAT_W-1:0]   repeat_count_r;
  logic [LED_W-1:0]      first_led_r;
  logic [LED_W-1:0]      led_end_r;

  // player state
  logic                  running_r, running_nxt;
  logic [FIDX_W-1:0]     frame_idx_r, frame_idx_nxt;
  logic [REPEAT_W-1:0]   repeats_r, repeats_nxt;
  logic [INTERVAL_W-1:0] ticks_r, ticks_nxt;

  logic              accept;
  logic              draw;
  logic [FIDX_W-1:0] idx_cur;
  logic [REPEAT_W-1:0] rep_cur;
  logic [FC_W-1:0]   frames_eff;
  logic [FC_W-1:0]   idx_next;
  draw_req_t         req;
  logic [FIDX_W-1:0] draw_idx;

  logic              eng_busy;
  logic              rd_en;
  logic [RAW-1:0]    rd_addr;
  logic [BYTE_W-1:0] rd_data;
  logic              st_we;

  assign accept = start && !busy;

  always_comb begin
    if (total_frames_r == '0) begin
      frames_eff = FC_W'(1);
    end else if (FC_W'(total_frames_r) > FC_W'(MAX_FRAMES)) begin
      frames_eff = FC_W'(MAX_FRAMES);
    end else begin
      frames_eff = FC_W'(total_frames_r);
    end
  end

  always_comb begin
    running_nxt   = running_r;
    frame_idx_nxt = frame_idx_r;
    repeats_nxt   = repeats_r;
    ticks_nxt     = ticks_r;
    draw          = 1'b0;
    req           = '0;
    idx_cur       = frame_idx_r;
    rep_cur       = repeats_r;
    if (accept) begin
      unique case (in_data.mode)
        MODE_TICK: begin
          if (running_r) begin
            if (ticks_r > INTERVAL_W'(1)) begin
              ticks_nxt = ticks_r - INTERVAL_W'(1);
            end else begin
              draw = 1'b1;
            end
          end
        end
        MODE_LOAD: begin
        end
        MODE_START: begin
          draw        = 1'b1;
          running_nxt = 1'b1;
          idx_cur     = '0;
          rep_cur     = repeat_count_r;
        end
        default: begin
          if (running_r) begin
            running_nxt = 1'b0;
            req.go      = 1'b1;
            req.blank   = 1'b1;
          end
        end
      endcase
    end
    idx_next = FC_W'(idx_cur) + FC_W'(1);
    if (draw) begin
      req.go        = 1'b1;
      frame_idx_nxt = idx_next[FIDX_W-1:0];
      repeats_nxt   = rep_cur;
      if (idx_next >= frames_eff) begin
        frame_idx_nxt = '0;
        if (rep_cur != '0) begin
          repeats_nxt = rep_cur - REPEAT_W'(1);
          // last pass done: stop and keep this frame on the display
          if (rep_cur == REPEAT_W'(1)) begin
            running_nxt = 1'b0;
            req.fin     = 1'b1;
          end
        end
      end
      if (running_nxt) begin
        ticks_nxt = frame_interval_r;
      end
    end
  end

  // blank-out walks frame zero with data masked
  assign draw_idx = req.blank ? '0 : idx_cur;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_interval_r <= INTERVAL_W'(40);
      total_frames_r   <= TOTAL_W'(44);
      repeat_count_r   <= '0;
      first_led_r      <= '0;
      led_end_r        <= LED_W'(LED_LIMIT);
      running_r        <= 1'b0;
      frame_idx_r      <= '0;
      repeats_r        <= '0;
      ticks_r          <= '0;
    end else begin
      running_r   <= running_nxt;
      frame_idx_r <= frame_idx_nxt;
      repeats_r   <= repeats_nxt;
      ticks_r     <= ticks_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_FRAME_INTERVAL: frame_interval_r <= cfg_wdata[INTERVAL_W-1:0];
          CFG_TOTAL_FRAMES:   total_frames_r   <= cfg_wdata[TOTAL_W-1:0];
          CFG_REPEAT_COUNT:   repeat_count_r   <= cfg_wdata[REPEAT_W-1:0];
          CFG_FIRST_LED:      first_led_r      <= cfg_wdata[LED_W-1:0];
          CFG_LED_END:        led_end_r        <= cfg_wdata[LED_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // loads are only taken while no frame walk reads the store
  assign st_we = accept && (in_data.mode == MODE_LOAD)
              && (32'(in_data.load_addr) < 32'(DEPTH));

  lfap_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (st_we),
    .waddr(RAW'(in_data.load_addr)),
    .wdata(in_data.load_data),
    .re   (rd_en),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  lfap_draw #(
    .FRAME_BYTES(FRAME_BYTES),
    .DEPTH      (DEPTH),
    .FIDX_W     (FIDX_W)
  ) u_draw (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (req),
    .frame_idx (draw_idx),
    .first_led (first_led_r),
    .led_end   (led_end_r),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .busy      (eng_busy),
    .out_strobe(out_strobe),
    .out_item  (out_data)
  );

  assign busy = eng_busy;

endmodule

/* rtl/core/lfap_ram.sv */
// lfap_ram: generic single-write, single-read synchronous ram
// registered read data; no dependencies
module lfap_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2304
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/lfap_draw.sv */
// lfap_draw: walks the led range of one frame, one store byte per cycle
// depends on lfap_pkg; drives the read port of the frame store ram
module lfap_draw
  import lfap_pkg::*;
#(
  parameter int FRAME_BYTES = 36,
  parameter int DEPTH       = 2304,
  parameter int FIDX_W      = 6
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  draw_req_t                req,
  input  logic [FIDX_W-1:0]        frame_idx,
  input  logic [LED_W-1:0]         first_led,
  input  logic [LED_W-1:0]         led_end,
  output logic                     rd_en,
  output logic [$clog2(DEPTH)-1:0] rd_addr,
  input  logic [BYTE_W-1:0]        rd_data,
  output logic                     busy,
  output logic                     out_strobe,
  output out_item_t                out_item
);

  localparam int RAW = $clog2(DEPTH);
  localparam int AW  = $clog2(DEPTH + LED_LIMIT * LED_BYTES);

  logic [LED_W-1:0] end_sat;
  logic [AW-1:0]    start_addr;

  // issue stage
  logic             act_r, act_nxt;
  logic [LED_W-1:0] led_r, led_nxt;
  logic [1:0]       ph_r, ph_nxt;
  logic [AW-1:0]    addr_r, addr_nxt;
  logic             blank_r, fin_r;

  // read data stage
  logic             p_vld_r;
  logic [1:0]       p_ph_r;
  logic [LED_W-1:0] p_led_r;
  logic             p_last_r;
  logic             p_oob_r;
  logic [BYTE_W-1:0] red_r, green_r;
  logic [BYTE_W-1:0] byte_val;

  logic      out_strobe_r;
  out_item_t out_r;

  assign end_sat = (led_end > LED_W'(LED_LIMIT)) ? LED_W'(LED_LIMIT) : led_end;
  assign start_addr = AW'(frame_idx) * AW'(FRAME_BYTES)
                    + AW'(first_led) * AW'(LED_BYTES);

  always_comb begin
    act_nxt  = act_r;
    led_nxt  = led_r;
    ph_nxt   = ph_r;
    addr_nxt = addr_r;
    if (req.go) begin
      act_nxt  = (first_led < end_sat);
      led_nxt  = first_led;
      ph_nxt   = 2'd0;
      addr_nxt = start_addr;
    end else if (act_r) begin
      addr_nxt = addr_r + AW'(1);
      if (ph_r == 2'd2) begin
        ph_nxt  = 2'd0;
        led_nxt = led_r + LED_W'(1);
        if (led_r + LED_W'(1) == end_sat) begin
          act_nxt = 1'b0;
        end
      end else begin
        ph_nxt = ph_r + 2'd1;
      end
    end
  end

  assign rd_en    = act_r;
  assign rd_addr  = addr_r[RAW-1:0];
  assign byte_val = (p_oob_r || blank_r) ? '0 : rd_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r        <= 1'b0;
      p_vld_r      <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      act_r        <= act_nxt;
      p_vld_r      <= act_r;
      out_strobe_r <= p_vld_r && (p_ph_r == 2'd2);
    end
    led_r  <= led_nxt;
    ph_r   <= ph_nxt;
    addr_r <= addr_nxt;
    if (req.go) begin
      blank_r <= req.blank;
      fin_r   <= req.fin;
    end
    p_ph_r   <= ph_r;
    p_led_r  <= led_r;
    p_last_r <= (led_r + LED_W'(1) == end_sat);
    p_oob_r  <= (addr_r >= AW'(DEPTH));
    if (p_vld_r) begin
      unique case (p_ph_r)
        2'd0: red_r <= byte_val;
        2'd1: green_r <= byte_val;
        default: begin
          out_r.led_index     <= p_led_r;
          out_r.red           <= red_r;
          out_r.green         <= green_r;
          out_r.blue          <= byte_val;
          out_r.last_of_frame <= p_last_r;
          out_r.finished      <= fin_r;
        end
      endcase
    end
  end

  assign busy       = act_r || p_vld_r;
  assign out_strobe = out_strobe_r;
  assign out_item   = out_r;

  // each led takes three store reads, so results never come back to back
  a_spaced: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |=> !out_strobe_r)
    else $error("results on consecutive cycles");

  a_no_launch_busy: assert property (@(posedge clk) disable iff (!rst_n)
    req.go |-> !busy)
    else $error("frame walk launched while busy");

  a_blank_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe_r && blank_r) |->
      (out_r.red == '0 && out_r.green == '0 && out_r.blue == '0 && !out_r.finished))
    else $error("blank-out result carries data");

  a_led_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |-> (out_r.led_index < end_sat && out_r.led_index >= first_led))
    else $error("led index outside range");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe_r && out_r.last_of_frame) |-> !act_r)
    else $error("frame walk continues after last result");

endmodule
